// ===== rtl/srmr_pkg.sv =====
`default_nettype none

package srmr_pkg;

  localparam int unsigned FuncW = 2;
  localparam int unsigned CmdW  = 32;
  localparam int unsigned CodeW = 16;
  localparam int unsigned DbmW  = 8;

  localparam logic [FuncW-1:0] FUNC_IDLE  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_READ  = 2'd2;

  localparam logic signed [DbmW-1:0] THRESH_RESET = -8'sd75;

  localparam logic [3:0] GAIN_0  = 4'h0;
  localparam logic [3:0] GAIN_4  = 4'h4;
  localparam logic [3:0] GAIN_8  = 4'h8;
  localparam logic [3:0] GAIN_9  = 4'h9;
  localparam logic [3:0] GAIN_10 = 4'hA;

  localparam logic [7:0] OFFS_0  = 8'd113;
  localparam logic [7:0] OFFS_4  = 8'd90;
  localparam logic [7:0] OFFS_8  = 8'd65;
  localparam logic [7:0] OFFS_9  = 8'd53;
  localparam logic [7:0] OFFS_10 = 8'd17;

  localparam logic signed [DbmW-1:0] RSSI_BASE = 8'sd98;

  // The gain nibble picks an offset that is added to the 7-bit level;
  // half of the corrected level, less the base, is the RSSI in dBm.
  function automatic logic signed [DbmW-1:0] decode_rssi(input logic [CodeW-1:0] code);
    logic [7:0] offs;
    logic [7:0] lvl;
    case (code[10:7])
      GAIN_0:  offs = OFFS_0;
      GAIN_4:  offs = OFFS_4;
      GAIN_8:  offs = OFFS_8;
      GAIN_9:  offs = OFFS_9;
      GAIN_10: offs = OFFS_10;
      default: offs = 8'd0;
    endcase
    lvl = {1'b0, code[6:0]} + offs;
    return $signed({1'b0, lvl[7:1]}) - RSSI_BASE;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srmr_in_if.sv =====
`default_nettype none

interface srmr_in_if;
  logic                           valid;
  logic                           ready;
  logic [srmr_pkg::FuncW-1:0]     func;
  logic [srmr_pkg::CmdW-1:0]      command_word;
  logic                           release_latch;
  logic                           serial_in;

  modport source (output valid, func, command_word, release_latch, serial_in, input ready);
  modport sink   (input valid, func, command_word, release_latch, serial_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/srmr_out_if.sv =====
`default_nettype none

interface srmr_out_if;
  logic                               valid;
  logic                               ready;
  logic                               clock_pin;
  logic                               data_pin;
  logic                               latch_pin;
  logic                               busy_res;
  logic                               done_res;
  logic [srmr_pkg::CodeW-1:0]         read_code;
  logic signed [srmr_pkg::DbmW-1:0]   rssi_dbm;
  logic                               channel_clear;

  modport source (output valid, clock_pin, data_pin, latch_pin, busy_res, done_res,
                  read_code, rssi_dbm, channel_clear, input ready);
  modport sink   (input valid, clock_pin, data_pin, latch_pin, busy_res, done_res,
                  read_code, rssi_dbm, channel_clear, output ready);
endinterface

`default_nettype wire

// ===== rtl/serial_register_master_rssi_core.sv =====
// Channel   Direction  Carries
// in_i      sink       one beat per serial tick: func, command_word, release_latch, serial_in
// out_o     source     one beat per input beat: pin levels, status, readback and RSSI
// cfg_*     write      clear_threshold_dbm, taken whenever cfg_we_i is high
//
// Each input beat is one tick of the serial line and yields one output beat in the next cycle.
// One beat a cycle is sustained while out_o.ready is high; the tick state machine and result register update together.
// A write takes 2 + 2*WORD_BITS ticks, a read 4 + 2*WORD_BITS + 2*READ_BITS ticks.
// Reset returns the line to idle with the latch low and the threshold at -75 dBm.
// While the result register is full and out_o.ready is low, in_i.ready is low.

`default_nettype none

module serial_register_master_rssi_core #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned READ_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  srmr_in_if.sink                            in_i,
  srmr_out_if.source                         out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [srmr_pkg::DbmW-1:0]     cfg_data_i
);

  localparam int unsigned MaxBits = (WORD_BITS > READ_BITS) ? WORD_BITS : READ_BITS;
  localparam int unsigned CntW    = $clog2(MaxBits);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SH_LO,
    PH_SH_HI,
    PH_LATCH,
    PH_DUM_HI,
    PH_DUM_LO,
    PH_RD_HI,
    PH_RD_LO
  } phase_e;

  typedef struct packed {
    logic                             clock_pin;
    logic                             data_pin;
    logic                             latch_pin;
    logic                             busy_res;
    logic                             done_res;
    logic [srmr_pkg::CodeW-1:0]       read_code;
    logic signed [srmr_pkg::DbmW-1:0] rssi_dbm;
    logic                             channel_clear;
  } result_t;

  phase_e                           phase_q, phase_d;
  logic [CntW-1:0]                  bit_cnt_q, bit_cnt_d;
  logic [WORD_BITS-1:0]             out_shift_q, out_shift_d;
  logic [srmr_pkg::CodeW-1:0]       in_shift_q, in_shift_d;
  logic                             is_read_q, is_read_d;
  logic                             keep_latch_q, keep_latch_d;
  logic [srmr_pkg::CodeW-1:0]       last_code_q, last_code_d;
  logic signed [srmr_pkg::DbmW-1:0] thresh_q;
  logic                             out_valid_q;
  result_t                          res_q, res_d;
  logic                             in_acc;
  logic                             start;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign start      = (in_i.func == srmr_pkg::FUNC_WRITE) || (in_i.func == srmr_pkg::FUNC_READ);

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    out_shift_d  = out_shift_q;
    in_shift_d   = in_shift_q;
    is_read_d    = is_read_q;
    keep_latch_d = keep_latch_q;
    last_code_d  = last_code_q;
    res_d        = '0;
    res_d.busy_res = 1'b1;

    unique case (phase_q)
      PH_IDLE: begin
        if (start) begin
          out_shift_d  = WORD_BITS'(in_i.command_word);
          is_read_d    = (in_i.func == srmr_pkg::FUNC_READ);
          keep_latch_d = !in_i.release_latch;
          bit_cnt_d    = '0;
          in_shift_d   = '0;
          phase_d      = PH_SH_LO;
        end else begin
          res_d.busy_res  = 1'b0;
          res_d.latch_pin = keep_latch_q;
        end
      end
      PH_SH_LO: begin
        res_d.data_pin = out_shift_q[WORD_BITS-1];
        phase_d        = PH_SH_HI;
      end
      PH_SH_HI: begin
        res_d.clock_pin = 1'b1;
        res_d.data_pin  = out_shift_q[WORD_BITS-1];
        out_shift_d     = {out_shift_q[WORD_BITS-2:0], 1'b0};
        if (bit_cnt_q == CntW'(WORD_BITS - 1)) begin
          bit_cnt_d = '0;
          phase_d   = PH_LATCH;
        end else begin
          bit_cnt_d = CntW'(bit_cnt_q + 1'b1);
          phase_d   = PH_SH_LO;
        end
      end
      PH_LATCH: begin
        res_d.latch_pin = 1'b1;
        if (is_read_q) begin
          phase_d = PH_DUM_HI;
        end else begin
          res_d.done_res = 1'b1;
          phase_d        = PH_IDLE;
        end
      end
      PH_DUM_HI: begin
        res_d.clock_pin = 1'b1;
        res_d.latch_pin = 1'b1;
        phase_d         = PH_DUM_LO;
      end
      PH_DUM_LO: begin
        res_d.latch_pin = 1'b1;
        bit_cnt_d       = '0;
        phase_d         = PH_RD_HI;
      end
      PH_RD_HI: begin
        res_d.clock_pin = 1'b1;
        res_d.latch_pin = 1'b1;
        phase_d         = PH_RD_LO;
      end
      PH_RD_LO: begin
        in_shift_d = {in_shift_q[srmr_pkg::CodeW-2:0], in_i.serial_in};
        if (bit_cnt_q == CntW'(READ_BITS - 1)) begin
          last_code_d    = in_shift_d;
          keep_latch_d   = 1'b0;
          bit_cnt_d      = '0;
          res_d.done_res = 1'b1;
          phase_d        = PH_IDLE;
        end else begin
          res_d.latch_pin = 1'b1;
          bit_cnt_d       = CntW'(bit_cnt_q + 1'b1);
          phase_d         = PH_RD_HI;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    res_d.read_code     = last_code_d;
    res_d.rssi_dbm      = srmr_pkg::decode_rssi(last_code_d);
    res_d.channel_clear = (res_d.rssi_dbm < thresh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= '0;
      out_shift_q  <= '0;
      in_shift_q   <= '0;
      is_read_q    <= 1'b0;
      keep_latch_q <= 1'b0;
      last_code_q  <= '0;
      out_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        bit_cnt_q    <= bit_cnt_d;
        out_shift_q  <= out_shift_d;
        in_shift_q   <= in_shift_d;
        is_read_q    <= is_read_d;
        keep_latch_q <= keep_latch_d;
        last_code_q  <= last_code_d;
        res_q        <= res_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= srmr_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= $signed(cfg_data_i);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.clock_pin     = res_q.clock_pin;
  assign out_o.data_pin      = res_q.data_pin;
  assign out_o.latch_pin     = res_q.latch_pin;
  assign out_o.busy_res      = res_q.busy_res;
  assign out_o.done_res      = res_q.done_res;
  assign out_o.read_code     = res_q.read_code;
  assign out_o.rssi_dbm      = res_q.rssi_dbm;
  assign out_o.channel_clear = res_q.channel_clear;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && out_valid_q && !out_o.ready))
    else $error("result register overwritten before its beat was taken");

  a_acc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_start_shifts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_IDLE && start) |=> (phase_q == PH_SH_LO && res_q.busy_res))
    else $error("command in idle did not start a transfer");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_d.done_res) |=> (phase_q == PH_IDLE && res_q.busy_res))
    else $error("transfer completion did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_serial_register_master_rssi_core.sv =====
`timescale 1ns / 1ps

module tb_serial_register_master_rssi_core;

  localparam int WORD_LEN = 32;
  localparam int READ_LEN = 16;
  localparam logic [srmr_pkg::FuncW-1:0] FUNC_SPARE = 2'd3;

  typedef enum logic [2:0] {
    LN_IDLE, LN_SH_LO, LN_SH_HI, LN_LATCH, LN_DUM_HI, LN_DUM_LO, LN_RD_HI, LN_RD_LO
  } line_phase_e;

  typedef struct packed {
    logic                        clock_pin;
    logic                        data_pin;
    logic                        latch_pin;
    logic                        busy;
    logic                        done;
    logic [srmr_pkg::CodeW-1:0]  code;
    logic [srmr_pkg::DbmW-1:0]   rssi;
    logic                        clear;
  } line_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [srmr_pkg::DbmW-1:0] cfg_data_i;

  srmr_in_if  in_ch ();
  srmr_out_if out_ch ();

  serial_register_master_rssi_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Line state as the testbench expects it to be.
  line_phase_e                       ln_phase;
  int                                bit_no;
  logic [WORD_LEN-1:0]               tx_word;
  logic [READ_LEN-1:0]               rx_word;
  logic                              rd_mode;
  logic                              idle_latch;
  logic [srmr_pkg::CodeW-1:0]        held_code;
  logic signed [srmr_pkg::DbmW-1:0]  clear_dbm;

  line_beat_t expected_beats[$];
  int err_count;
  int beat_count;
  int tick_count;
  int gap_pct;
  int stall_pct;
  int stall_left;

  always #4 clk_i = ~clk_i;

  function automatic int rssi_of(input logic [srmr_pkg::CodeW-1:0] code);
    int lvl;
    lvl = int'(code[6:0]);
    case (code[10:7])
      srmr_pkg::GAIN_0:  lvl += int'(srmr_pkg::OFFS_0);
      srmr_pkg::GAIN_4:  lvl += int'(srmr_pkg::OFFS_4);
      srmr_pkg::GAIN_8:  lvl += int'(srmr_pkg::OFFS_8);
      srmr_pkg::GAIN_9:  lvl += int'(srmr_pkg::OFFS_9);
      srmr_pkg::GAIN_10: lvl += int'(srmr_pkg::OFFS_10);
      default: ;
    endcase
    return (lvl >> 1) - int'(srmr_pkg::RSSI_BASE);
  endfunction

  function automatic line_beat_t advance_line(input logic [srmr_pkg::FuncW-1:0] fn,
                                              input logic [srmr_pkg::CmdW-1:0] word,
                                              input logic rel, input logic sin);
    line_beat_t b;
    int r;
    b = '0;
    b.busy = 1'b1;
    case (ln_phase)
      LN_IDLE: begin
        if (fn == srmr_pkg::FUNC_WRITE || fn == srmr_pkg::FUNC_READ) begin
          tx_word = word;
          rd_mode = (fn == srmr_pkg::FUNC_READ);
          idle_latch = !rel;
          bit_no = 0;
          rx_word = '0;
          ln_phase = LN_SH_LO;
        end else begin
          b.busy = 1'b0;
          b.latch_pin = idle_latch;
        end
      end
      LN_SH_LO: begin
        b.data_pin = tx_word[WORD_LEN-1];
        ln_phase = LN_SH_HI;
      end
      LN_SH_HI: begin
        b.clock_pin = 1'b1;
        b.data_pin = tx_word[WORD_LEN-1];
        tx_word = tx_word << 1;
        if (bit_no >= WORD_LEN - 1) begin
          bit_no = 0;
          ln_phase = LN_LATCH;
        end else begin
          bit_no++;
          ln_phase = LN_SH_LO;
        end
      end
      LN_LATCH: begin
        b.latch_pin = 1'b1;
        if (rd_mode) begin
          ln_phase = LN_DUM_HI;
        end else begin
          b.done = 1'b1;
          ln_phase = LN_IDLE;
        end
      end
      LN_DUM_HI: begin
        b.clock_pin = 1'b1;
        b.latch_pin = 1'b1;
        ln_phase = LN_DUM_LO;
      end
      LN_DUM_LO: begin
        b.latch_pin = 1'b1;
        bit_no = 0;
        ln_phase = LN_RD_HI;
      end
      LN_RD_HI: begin
        b.clock_pin = 1'b1;
        b.latch_pin = 1'b1;
        ln_phase = LN_RD_LO;
      end
      default: begin
        rx_word = {rx_word[READ_LEN-2:0], sin};
        if (bit_no >= READ_LEN - 1) begin
          held_code = rx_word;
          idle_latch = 1'b0;
          bit_no = 0;
          b.done = 1'b1;
          ln_phase = LN_IDLE;
        end else begin
          b.latch_pin = 1'b1;
          bit_no++;
          ln_phase = LN_RD_HI;
        end
      end
    endcase
    r = rssi_of(held_code);
    b.code = held_code;
    b.rssi = r[srmr_pkg::DbmW-1:0];
    b.clear = (r < int'(clear_dbm));
    return b;
  endfunction

  task check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= 10)
        $display("beat %0d %s: expected %h, got %h", beat_count, fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    line_beat_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        expected_beats.push_back(advance_line(in_ch.func, in_ch.command_word,
                                              in_ch.release_latch, in_ch.serial_in));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("beat %0d: output beat with nothing expected", beat_count);
        end else begin
          want = expected_beats.pop_front();
          check_field("clock_pin", 16'(want.clock_pin), 16'(out_ch.clock_pin));
          check_field("data_pin", 16'(want.data_pin), 16'(out_ch.data_pin));
          check_field("latch_pin", 16'(want.latch_pin), 16'(out_ch.latch_pin));
          check_field("busy_res", 16'(want.busy), 16'(out_ch.busy_res));
          check_field("done_res", 16'(want.done), 16'(out_ch.done_res));
          check_field("read_code", want.code, out_ch.read_code);
          check_field("rssi_dbm", 16'(want.rssi), 16'($unsigned(out_ch.rssi_dbm)));
          check_field("channel_clear", 16'(want.clear), 16'(out_ch.channel_clear));
        end
        beat_count++;
      end
    end
  end

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ch.ready = 1'b0;
      stall_left = pick_len() - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_tick(input logic [srmr_pkg::FuncW-1:0] fn,
                           input logic [srmr_pkg::CmdW-1:0] word,
                           input logic rel, input logic sin);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_len() : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.func = fn;
    in_ch.command_word = word;
    in_ch.release_latch = rel;
    in_ch.serial_in = sin;
    do @(posedge clk_i); while (!in_ch.ready);
    tick_count++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_threshold(input logic signed [srmr_pkg::DbmW-1:0] dbm);
    drain();
    cfg_data_i = dbm;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    clear_dbm = dbm;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n)
      send_tick($urandom_range(0, 1) ? srmr_pkg::FUNC_IDLE : FUNC_SPARE, $urandom,
                1'($urandom), 1'($urandom));
  endtask

  function automatic logic [srmr_pkg::CodeW-1:0] pick_code();
    logic [srmr_pkg::CodeW-1:0] c;
    c = 16'($urandom);
    case ($urandom_range(0, 5))
      0: c[10:7] = srmr_pkg::GAIN_0;
      1: c[10:7] = srmr_pkg::GAIN_4;
      2: c[10:7] = srmr_pkg::GAIN_8;
      3: c[10:7] = srmr_pkg::GAIN_9;
      4: c[10:7] = srmr_pkg::GAIN_10;
      default: ;
    endcase
    return c;
  endfunction

  // The serial input follows the planned code on the sampling ticks and is noise elsewhere;
  // commands issued while the line is busy must be ignored.
  task automatic run_transfer(input logic [srmr_pkg::FuncW-1:0] fn,
                              input logic [srmr_pkg::CmdW-1:0] word,
                              input logic rel, input logic [srmr_pkg::CodeW-1:0] code,
                              input int noise_pct);
    logic [srmr_pkg::FuncW-1:0] f;
    logic s;
    send_tick(fn, word, rel, 1'($urandom));
    while (ln_phase != LN_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) f = 2'($urandom);
      else f = ($urandom_range(0, 3) == 0) ? FUNC_SPARE : srmr_pkg::FUNC_IDLE;
      s = (ln_phase == LN_RD_LO) ? code[READ_LEN-1-bit_no] : 1'($urandom);
      send_tick(f, $urandom, 1'($urandom), s);
    end
  endtask

  task automatic test_reset_state();
    gap_pct = 0;
    stall_pct = 0;
    send_tick(srmr_pkg::FUNC_IDLE, '0, 1'b0, 1'b0);
    send_tick(FUNC_SPARE, '1, 1'b1, 1'b1);
    idle_ticks(3);
    drain();
  endtask

  task automatic test_writes();
    run_transfer(srmr_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 1'b0, '0, 0);
    idle_ticks(2);
    run_transfer(srmr_pkg::FUNC_WRITE, 32'h0000_0000, 1'b1, '0, 0);
    idle_ticks(2);
    gap_pct = 30;
    stall_pct = 30;
    run_transfer(srmr_pkg::FUNC_WRITE, 32'h8000_0001, 1'b0, '0, 40);
    idle_ticks(2);
    run_transfer(srmr_pkg::FUNC_WRITE, 32'h5A5A_A5A5, 1'b1, '0, 40);
    idle_ticks(2);
    drain();
  endtask

  task automatic test_reads();
    logic [srmr_pkg::CodeW-1:0] codes[7];
    codes = '{16'h0000, 16'hFFFF, 16'h027F, 16'h0400, 16'h04C5, 16'h0500, 16'h8B2A};
    foreach (codes[i]) begin
      run_transfer(srmr_pkg::FUNC_READ, $urandom, 1'($urandom), codes[i], (i % 2) * 30);
      idle_ticks(2);
    end
    run_transfer(srmr_pkg::FUNC_WRITE, $urandom, 1'b0, '0, 0);
    run_transfer(srmr_pkg::FUNC_READ, $urandom, 1'b0, 16'h1234, 0);
    idle_ticks(2);
    drain();
  endtask

  task automatic test_threshold();
    logic signed [srmr_pkg::DbmW-1:0] levels[6];
    logic [srmr_pkg::CodeW-1:0] probes[2];
    levels = '{-8'sd128, 8'sd127, -8'sd97, -8'sd98, 8'sd22, 8'sd23};
    probes = '{16'h007F, 16'h0780};
    foreach (probes[j]) begin
      run_transfer(srmr_pkg::FUNC_READ, $urandom, 1'b0, probes[j], 0);
      idle_ticks(2);
      foreach (levels[i]) begin
        set_threshold(levels[i]);
        idle_ticks(3);
      end
    end
    set_threshold(srmr_pkg::THRESH_RESET);
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = 1800;
    while (tick_count < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 60);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 60);
      end
      idle_ticks($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 5) begin
        case ($urandom_range(0, 3))
          0: set_threshold(-8'sd128);
          1: set_threshold(8'sd127);
          default: set_threshold(8'($urandom_range(0, 255)));
        endcase
      end else begin
        run_transfer($urandom_range(0, 1) ? srmr_pkg::FUNC_WRITE : srmr_pkg::FUNC_READ,
                     $urandom, 1'($urandom), pick_code(), 10);
      end
    end
    drain();
  endtask

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.func = srmr_pkg::FUNC_IDLE;
    in_ch.command_word = '0;
    in_ch.release_latch = 1'b0;
    in_ch.serial_in = 1'b0;
    out_ch.ready = 1'b1;
    ln_phase = LN_IDLE;
    bit_no = 0;
    tx_word = '0;
    rx_word = '0;
    rd_mode = 1'b0;
    idle_latch = 1'b0;
    held_code = '0;
    clear_dbm = srmr_pkg::THRESH_RESET;
    err_count = 0;
    beat_count = 0;
    tick_count = 0;
    gap_pct = 0;
    stall_pct = 0;
    stall_left = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_writes();
    test_reads();
    test_threshold();
    test_random();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/srmr_pkg.sv
rtl/srmr_in_if.sv
rtl/srmr_out_if.sv
rtl/serial_register_master_rssi_core.sv
tb/tb_serial_register_master_rssi_core.sv
